@@ hw/rtl/ipc_pkg.sv @@
// Package for the irrigation pump controller.
// Holds field types, register indexes, reset values and LED codes; no dependencies.
`default_nettype none

package ipc_pkg;

  localparam int unsigned PctW = 7;
  localparam int unsigned MsW  = 32;

  typedef logic [PctW-1:0] pct_t;
  typedef logic [MsW-1:0]  ms_t;

  typedef enum logic [1:0] {
    CFG_MOIST_LOW  = 2'd0,
    CFG_MOIST_HIGH = 2'd1,
    CFG_WATER_MAX  = 2'd2,
    CFG_PERIOD     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LED_OK    = 2'd0,
    LED_ALERT = 2'd1,
    LED_WATER = 2'd2
  } led_t;

  localparam pct_t MoistLowReset  = pct_t'(30);
  localparam pct_t MoistHighReset = pct_t'(70);
  localparam ms_t  WaterMaxReset  = ms_t'(10000);
  localparam ms_t  PeriodReset    = ms_t'(1000);
  localparam ms_t  WaterStepMs    = ms_t'(100);

endpackage

`default_nettype wire

@@ hw/rtl/irrigation_pump_controller.sv @@
// Irrigation pump controller: mode, pump and LED control, one result per control item.
// Depends on ipc_pkg.
`default_nettype none

// Each accepted item is one control tick; its result appears in the output register
// on the next cycle and a new item is taken every cycle unless the output register
// is full and stalled. The single result register follows the update logic; the state
// (mode, pump, watering time, last check time) is updated at the same edge that
// accepts the item.
module irrigation_pump_controller (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_index,
  input  wire ipc_pkg::ms_t    cfg_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ipc_pkg::pct_t   moisture,
  input  wire logic            mode_button,
  input  wire logic            water_button,
  input  wire ipc_pkg::ms_t    time_now_ms,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 pump_on,
  output logic                 manual_mode,
  output logic [1:0]           led_code,
  output logic                 mode_toggled,
  output logic                 watering_started,
  output logic                 watering_stopped
);
  import ipc_pkg::*;

  pct_t moist_low;
  pct_t moist_high;
  ms_t  water_max;
  ms_t  period;

  logic manual_flag;
  logic pump_running;
  ms_t  elapsed;
  ms_t  last_check;

  logic manual_next;
  logic pump_kept;
  logic start_manual;
  logic check_due;
  logic start_auto;
  logic started;
  logic pump_active;
  ms_t  elapsed_base;
  logic [MsW:0] elapsed_sum;
  ms_t  elapsed_next;
  logic stop;
  logic pump_next;
  logic dry;
  led_t led_next;
  logic accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    manual_next  = manual_flag ^ mode_button;
    pump_kept    = pump_running & ~(mode_button & manual_next);
    start_manual = manual_next & water_button & ~pump_kept;
    check_due    = ~manual_next & ((time_now_ms - last_check) >= period);
    dry          = moisture < moist_low;
    start_auto   = check_due & ~pump_kept & dry;
    started      = start_manual | start_auto;
    pump_active  = pump_kept | started;
    elapsed_base = started ? '0 : elapsed;
    elapsed_sum  = {1'b0, elapsed_base} + {1'b0, WaterStepMs};
    elapsed_next = elapsed_sum[MsW] ? '1 : elapsed_sum[MsW-1:0];
    stop         = pump_active &
                   ((elapsed_next >= water_max) | (~manual_next & (moisture >= moist_high)));
    pump_next    = pump_active & ~stop;
    priority if (pump_next) begin
      led_next = LED_WATER;
    end else if (dry) begin
      led_next = LED_ALERT;
    end else begin
      led_next = LED_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moist_low  <= MoistLowReset;
      moist_high <= MoistHighReset;
      water_max  <= WaterMaxReset;
      period     <= PeriodReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MOIST_LOW:  moist_low  <= cfg_data[PctW-1:0];
        CFG_MOIST_HIGH: moist_high <= cfg_data[PctW-1:0];
        CFG_WATER_MAX:  water_max  <= cfg_data;
        CFG_PERIOD:     period     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_flag  <= 1'b0;
      pump_running <= 1'b0;
      elapsed      <= '0;
      last_check   <= '0;
    end else if (accept) begin
      manual_flag  <= manual_next;
      pump_running <= pump_next;
      if (pump_active) begin
        elapsed <= elapsed_next;
      end
      if (check_due) begin
        last_check <= time_now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pump_on          <= pump_next;
      manual_mode      <= manual_next;
      led_code         <= led_next;
      mode_toggled     <= mode_button;
      watering_started <= started;
      watering_stopped <= stop;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_pump_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pump_on == (led_code == LED_WATER)))
    else $error("LED code disagrees with pump state");

  a_stop_clears_pump: assert property (@(posedge clk) disable iff (rst)
    (out_valid && watering_stopped) |-> !pump_on)
    else $error("pump on after stop event");

  a_start_sets_pump: assert property (@(posedge clk) disable iff (rst)
    (out_valid && watering_started && !watering_stopped) |-> pump_on)
    else $error("pump off after start event");

  a_state_matches_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pump_running == pump_on) && (manual_flag == manual_mode))
    else $error("state and result registers diverge");

endmodule

`default_nettype wire

@@ tb/irrigation_pump_controller_tb.sv @@
// Self-checking testbench for irrigation_pump_controller: a queue-fed driver, a monitor
// with random stall and hold-off, and a per-item predictor of mode, pump, LED and events.
// Depends on ipc_pkg and the irrigation_pump_controller RTL.
`timescale 1ns / 1ps

module irrigation_pump_controller_tb;
  import ipc_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    pct_t moisture;
    logic mode_button;
    logic water_button;
    ms_t  time_now_ms;
  } ctl_item_t;

  typedef struct {
    logic pump_on;
    logic manual_mode;
    led_t led;
    logic toggled;
    logic started;
    logic stopped;
  } ctl_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  ms_t        cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pct_t       moisture = '0;
  logic       mode_button = 1'b0;
  logic       water_button = 1'b0;
  ms_t        time_now_ms = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       pump_on;
  logic       manual_mode;
  logic [1:0] led_code;
  logic       mode_toggled;
  logic       watering_started;
  logic       watering_stopped;

  irrigation_pump_controller u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .moisture         (moisture),
    .mode_button      (mode_button),
    .water_button     (water_button),
    .time_now_ms      (time_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pump_on          (pump_on),
    .manual_mode      (manual_mode),
    .led_code         (led_code),
    .mode_toggled     (mode_toggled),
    .watering_started (watering_started),
    .watering_stopped (watering_stopped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and configuration
  pct_t low_lim_q   = MoistLowReset;
  pct_t high_lim_q  = MoistHighReset;
  ms_t  water_max_q = WaterMaxReset;
  ms_t  period_q    = PeriodReset;
  logic manual_q    = 1'b0;
  logic pump_q      = 1'b0;
  ms_t  elapsed_q   = '0;
  ms_t  last_check_q = '0;

  ctl_item_t   ctl_items[$];
  ctl_result_t pump_results_due[$];
  ctl_item_t   cur_item;
  ctl_result_t want;
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_left = 0;
  ms_t         t_now = '0;

  function automatic ctl_result_t pump_step(ctl_item_t it);
    ctl_result_t r;
    ms_t         since;
    r.toggled = 1'b0;
    r.started = 1'b0;
    r.stopped = 1'b0;
    if (it.mode_button) begin
      manual_q = !manual_q;
      r.toggled = 1'b1;
      if (manual_q) pump_q = 1'b0;
    end
    if (manual_q && it.water_button && !pump_q) begin
      pump_q = 1'b1;
      r.started = 1'b1;
      elapsed_q = '0;
    end
    since = it.time_now_ms - last_check_q;
    if (!manual_q && since >= period_q) begin
      last_check_q = it.time_now_ms;
      if (!pump_q && it.moisture < low_lim_q) begin
        pump_q = 1'b1;
        r.started = 1'b1;
        elapsed_q = '0;
      end
    end
    if (pump_q) begin
      if (elapsed_q > ms_t'('1) - WaterStepMs) elapsed_q = '1;
      else elapsed_q = elapsed_q + WaterStepMs;
      if (elapsed_q >= water_max_q || (!manual_q && it.moisture >= high_lim_q)) begin
        pump_q = 1'b0;
        r.stopped = 1'b1;
      end
    end
    if (pump_q) r.led = LED_WATER;
    else if (it.moisture < low_lim_q) r.led = LED_ALERT;
    else r.led = LED_OK;
    r.pump_on = pump_q;
    r.manual_mode = manual_q;
    return r;
  endfunction

  function automatic ctl_item_t random_item();
    ctl_item_t it;
    int        sel;
    sel = $urandom_range(99);
    if (sel < 20) t_now = t_now;
    else if (sel < 60) t_now = t_now + ms_t'($urandom_range(300));
    else if (sel < 90) t_now = t_now + ms_t'($urandom_range(2500));
    else t_now = $urandom;
    if ($urandom_range(99) < 85) it.moisture = pct_t'($urandom_range(100));
    else it.moisture = pct_t'($urandom_range(127));
    it.mode_button = ($urandom_range(99) < 8);
    it.water_button = ($urandom_range(99) < 25);
    it.time_now_ms = t_now;
    return it;
  endfunction

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, ms_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MOIST_LOW:  low_lim_q = pct_t'(val);
      CFG_MOIST_HIGH: high_lim_q = pct_t'(val);
      CFG_WATER_MAX:  water_max_q = val;
      CFG_PERIOD:     period_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(ms_t low, ms_t high, ms_t wmax, ms_t period);
    write_reg(CFG_MOIST_LOW, low);
    write_reg(CFG_MOIST_HIGH, high);
    write_reg(CFG_WATER_MAX, wmax);
    write_reg(CFG_PERIOD, period);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (ctl_items.size() != 0 || in_valid || pump_results_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // driver: predict on acceptance, hold payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pump_results_due.push_back(pump_step(cur_item));
      if (!in_valid || !in_stall) begin
        if (ctl_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_item = ctl_items.pop_front();
          in_valid <= 1'b1;
          moisture <= cur_item.moisture;
          mode_button <= cur_item.mode_button;
          water_button <= cur_item.water_button;
          time_now_ms <= cur_item.time_now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare results, drive stall and long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pump_results_due.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = pump_results_due.pop_front();
        check_field("pump_on", want.pump_on, pump_on);
        check_field("manual_mode", want.manual_mode, manual_mode);
        check_field("led_code", int'(want.led), led_code);
        check_field("mode_toggled", want.toggled, mode_toggled);
        check_field("watering_started", want.started, watering_started);
        check_field("watering_stopped", want.stopped, watering_stopped);
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL irrigation_pump_controller");
      $finish;
    end
  end

  initial begin
    snd_idle_pct = 30;
    rcv_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed items under reset configuration
    ctl_items.push_back('{pct_t'(50),  1'b0, 1'b0, ms_t'(0)});
    ctl_items.push_back('{pct_t'(10),  1'b0, 1'b0, ms_t'(1000)});
    ctl_items.push_back('{pct_t'(80),  1'b0, 1'b0, ms_t'(1100)});
    ctl_items.push_back('{pct_t'(10),  1'b0, 1'b0, ms_t'(1500)});
    ctl_items.push_back('{pct_t'(0),   1'b1, 1'b0, ms_t'(1600)});
    ctl_items.push_back('{pct_t'(127), 1'b0, 1'b1, ms_t'(1700)});
    ctl_items.push_back('{pct_t'(100), 1'b1, 1'b0, ms_t'(1800)});
    ctl_items.push_back('{pct_t'(20),  1'b0, 1'b0, ms_t'(2000)});
    ctl_items.push_back('{pct_t'(20),  1'b1, 1'b0, ms_t'(2100)});
    ctl_items.push_back('{pct_t'(20),  1'b0, 1'b1, ms_t'(2200)});
    ctl_items.push_back('{pct_t'(20),  1'b1, 1'b1, ms_t'(2300)});
    ctl_items.push_back('{pct_t'(20),  1'b1, 1'b1, ms_t'(2400)});
    ctl_items.push_back('{pct_t'(0),   1'b0, 1'b0, ms_t'(32'hFFFF_FF00)});
    ctl_items.push_back('{pct_t'(0),   1'b1, 1'b0, ms_t'(32'hFFFF_FFFF)});
    ctl_items.push_back('{pct_t'(30),  1'b0, 1'b0, ms_t'(32'h0000_0010)});
    ctl_items.push_back('{pct_t'(29),  1'b0, 1'b0, ms_t'(32'h0000_03E7)});
    ctl_items.push_back('{pct_t'(70),  1'b0, 1'b0, ms_t'(32'h0000_0400)});
    ctl_items.push_back('{pct_t'(69),  1'b0, 1'b0, ms_t'(32'h0000_07D0)});
    ctl_items.push_back('{pct_t'(100), 1'b0, 1'b1, ms_t'(32'h0000_0800)});
    ctl_items.push_back('{pct_t'(127), 1'b1, 1'b1, ms_t'(32'h0000_0900)});
    ctl_items.push_back('{pct_t'(101), 1'b0, 1'b0, ms_t'(32'h0000_0A00)});
    t_now = ms_t'(32'h0000_0A00);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        snd_idle_pct = 30;
        rcv_idle_pct = 53;
      end else if (ph < 6) begin
        snd_idle_pct = 53;
        rcv_idle_pct = 30;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (ph)
        0: apply_cfg('0, '0, '0, '0);
        1: apply_cfg(ms_t'(100), ms_t'(100), '1, '1);
        2: apply_cfg('1, ms_t'(127), ms_t'(500), '0);
        3: apply_cfg(ms_t'(40), ms_t'(60), ms_t'(1500), ms_t'(300));
        4: apply_cfg(ms_t'(50), ms_t'(20), ms_t'(100), ms_t'(1));
        5: apply_cfg(ms_t'($urandom_range(100)), ms_t'($urandom_range(100)),
                     ms_t'($urandom_range(3000, 100)), ms_t'($urandom_range(2000)));
        6: apply_cfg(ms_t'(MoistLowReset), ms_t'(MoistHighReset), WaterMaxReset,
                     PeriodReset);
        default: apply_cfg($urandom, $urandom, $urandom, $urandom);
      endcase
      for (int i = 0; i < 241; i++) ctl_items.push_back(random_item());
      if (ph == 4) begin
        @(negedge clk);
        hold_left = 300;
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (errors == 0) $display("PASS irrigation_pump_controller");
    else $display("FAIL irrigation_pump_controller");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ipc_pkg.sv
hw/rtl/irrigation_pump_controller.sv
tb/irrigation_pump_controller_tb.sv
